// ----- hw/rtl/b32d_pkg.sv -----
// Shared types and constants for the Base32 symbol decoder.
// Depends on nothing; b32d_core and base32_symbol_decoder import it.
`default_nettype none

package b32d_pkg;

   localparam int CHAR_W = 8;              // width of one input character
   localparam int SYM_W  = 5;              // width of one Base32 symbol
   localparam int BYTE_W = 8;              // width of one decoded byte
   localparam int HELD_W = 3;              // pending bit count, 0..7 between beats
   localparam int KEEP_W = BYTE_W - 1;     // buffer bits that can still be pending

   // Alphabet choice held in the configuration register.
   typedef enum logic [0:0] {
      ALPHA_STD    = 1'b0,                 // A-Z then 2-7
      ALPHA_LEGACY = 1'b1                  // A-Z without I and O, then 2-9
   } alphabet_type;

   // One result beat as produced by the decode core.
   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] byte_out;
      logic              char_skipped;
      logic              string_end;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/b32d_core.sv -----
// Decode core: character to symbol lookup, bit buffer and byte extraction.
// Depends on b32d_pkg.
`default_nettype none

module b32d_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,      // consume the presented character
   input  wire logic [b32d_pkg::CHAR_W-1:0]  char_in,
   input  wire logic                         last_char,
   input  wire b32d_pkg::alphabet_type       alphabet,
   output b32d_pkg::result_type              result
);
   import b32d_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [SYM_W-1:0] sym;
   } lookup_type;

   // Reverse lookup of one character in the selected alphabet.
   function automatic lookup_type symbol_of(input logic [CHAR_W-1:0] c_raw,
                                            input alphabet_type sel);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] diff;
      lookup_type        res;
      c        = c_raw;
      diff     = '0;
      res.hit  = 1'b0;
      res.sym  = '0;
      // Fold lower case onto upper case.
      if (c inside {[8'h61:8'h7A]}) begin
         c = c - 8'h20;
      end
      case (sel)
         ALPHA_STD: begin
            if (c inside {[8'h41:8'h5A]}) begin
               diff    = c - 8'h41;
               res.hit = 1'b1;
            end else if (c inside {[8'h32:8'h37]}) begin
               diff    = c - 8'h18;
               res.hit = 1'b1;
            end
         end
         ALPHA_LEGACY: begin
            if (c inside {[8'h41:8'h48]}) begin
               diff    = c - 8'h41;
               res.hit = 1'b1;
            end else if (c inside {[8'h4A:8'h4E]}) begin
               diff    = c - 8'h42;
               res.hit = 1'b1;
            end else if (c inside {[8'h50:8'h5A]}) begin
               diff    = c - 8'h43;
               res.hit = 1'b1;
            end else if (c inside {[8'h32:8'h39]}) begin
               diff    = c - 8'h1A;
               res.hit = 1'b1;
            end
         end
         default: begin
            res.hit = 1'b0;
         end
      endcase
      res.sym = diff[SYM_W-1:0];
      return res;
   endfunction

   logic [KEEP_W-1:0]       buf_ff,  buf_in;
   logic [HELD_W-1:0]       held_ff, held_in;

   lookup_type              look;
   logic [KEEP_W+SYM_W-1:0] merged;
   logic [HELD_W:0]         held_sum;
   logic [HELD_W:0]         shift;
   logic [KEEP_W+SYM_W-1:0] shifted;
   logic                    full;

   always_comb begin
      look     = symbol_of(char_in, alphabet);
      merged   = {buf_ff, look.sym};
      held_sum = {1'b0, held_ff} + (HELD_W+1)'(SYM_W);
      full     = (held_sum >= (HELD_W+1)'(BYTE_W));
      shift    = held_sum - (HELD_W+1)'(BYTE_W);
      shifted  = merged >> shift;

      result.byte_valid   = look.hit && full;
      result.byte_out     = (look.hit && full) ? shifted[BYTE_W-1:0] : '0;
      result.char_skipped = !look.hit;
      result.string_end   = last_char;

      buf_in  = buf_ff;
      held_in = held_ff;
      if (look.hit) begin
         buf_in  = merged[KEEP_W-1:0];
         held_in = full ? shift[HELD_W-1:0] : held_sum[HELD_W-1:0];
      end
      if (last_char) begin
         buf_in  = '0;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         held_ff <= '0;
      end else if (advance) begin
         buf_ff  <= buf_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/base32_symbol_decoder.sv -----
// Top level of the Base32 symbol decoder: input register, decode core and
// result register with stream handshakes. Depends on b32d_pkg and b32d_core.
//
//   Port group   Direction  Beat contents
//   req_*        in         one character (tdata) and end-of-string mark (tlast)
//   rsp_*        out        decoded byte (tdata), byte/skip flags (tuser), tlast echo
//   csr_*        in         alphabet select write, no read-back
//
// Every character yields exactly one result beat. A character enters the
// input register, and its result then goes into the result register. One
// character is taken per cycle while the result side keeps up. The bit
// buffer in the decode core advances as the character moves from the
// input register into the result register. Reset is synchronous and
// clears the valid flags, the bit buffer and the alphabet select
// (standard alphabet). When rsp_tready is low and the result register is
// full, both registers hold, and req_tready drops once the input register
// is also occupied.
`default_nettype none

module base32_symbol_decoder (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [b32d_pkg::CHAR_W-1:0]  req_tdata,   // [7:0] char_in
   input  wire logic                         req_tlast,   // last_char

   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [b32d_pkg::BYTE_W-1:0]       rsp_tdata,   // [7:0] byte_out
   output logic [1:0]                        rsp_tuser,   // [0] byte_valid, [1] char_skipped
   output logic                              rsp_tlast,   // string_end

   input  wire logic                         csr_we,
   input  wire logic                         csr_wdata    // alphabet_select
);
   import b32d_pkg::*;

   alphabet_type       alpha_ff;

   logic               in_valid_ff;
   logic [CHAR_W-1:0]  in_char_ff;
   logic               in_last_ff;

   logic               out_valid_ff;
   result_type         out_ff;

   result_type         core_result;
   logic               out_free;
   logic               advance;
   logic               req_fire;

   // The result register can take a new beat when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   b32d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .char_in   (in_char_ff),
      .last_char (in_last_ff),
      .alphabet  (alpha_ff),
      .result    (core_result)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_STD;
      end else if (csr_we) begin
         alpha_ff <= alphabet_type'(csr_wdata);
      end
   end

   // Input register: loads on every accepted beat, empties when it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.byte_out;
   assign rsp_tuser  = {out_ff.char_skipped, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.string_end;

   // A skipped character never completes a byte.
   a_skip_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result flags both a byte and a skipped character");

   // The byte field is zero whenever no byte was completed.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero byte without byte_valid");

   // A character waiting on a stalled result register stays put.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_char_ff)
                                     && $stable(in_last_ff)))
      else $error("input register changed while stalled");

   // An advancing character always lands in the result register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced character produced no result beat");

endmodule

`default_nettype wire

// ----- bench/base32_symbol_decoder_tb.sv -----
// Self-checking testbench for base32_symbol_decoder: random and directed
// character streams, a scoreboard class that predicts every result beat.
// Depends on b32d_pkg and the RTL of the decoder; reads no files.
`timescale 1ns / 1ps

module base32_symbol_decoder_tb;
   import b32d_pkg::*;

   // Tracks the decoder state on its own and keeps the expected result beats.
   class decoded_byte_board;
      alphabet_type     alphabet;
      logic [11:0]      bit_buffer;
      logic [3:0]       bits_held;
      result_type       expected_beats[$];
      int               mismatches;
      int               beats_checked;
      int               bytes_seen;
      int               skips_seen;
      int               strings_seen;

      function new();
         alphabet      = ALPHA_STD;
         bit_buffer    = '0;
         bits_held     = '0;
         mismatches    = 0;
         beats_checked = 0;
         bytes_seen    = 0;
         skips_seen    = 0;
         strings_seen  = 0;
      endfunction

      function void set_alphabet(alphabet_type a);
         alphabet = a;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Symbol value of an upper-case character, or -1 when it is not a symbol.
      function int symbol_value(logic [7:0] ch);
         if (alphabet == ALPHA_STD) begin
            if (ch >= "A" && ch <= "Z") return ch - "A";
            if (ch >= "2" && ch <= "7") return ch - "2" + 26;
         end else begin
            if (ch >= "A" && ch <= "H") return ch - "A";
            if (ch >= "J" && ch <= "N") return ch - "A" - 1;
            if (ch >= "P" && ch <= "Z") return ch - "A" - 2;
            if (ch >= "2" && ch <= "9") return ch - "2" + 24;
         end
         return -1;
      endfunction

      // Works out the result of one accepted character and queues it.
      function void predict_char(logic [7:0] ch, logic last);
         logic [7:0] folded;
         logic [3:0] held;
         result_type beat;
         int         sym;
         folded = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
         sym    = symbol_value(folded);
         beat   = '0;
         if (sym < 0) begin
            beat.char_skipped = 1'b1;
         end else begin
            held       = bits_held + 4'd5;
            bit_buffer = {bit_buffer[6:0], sym[4:0]};
            if (held >= 4'd8) begin
               beat.byte_out   = 8'(bit_buffer >> (held - 4'd8));
               beat.byte_valid = 1'b1;
               held            = held - 4'd8;
            end
            bits_held = held;
         end
         if (last) begin
            bit_buffer = '0;
            bits_held  = '0;
         end
         beat.string_end = last;
         expected_beats.push_back(beat);
      endfunction

      // Compares one accepted result beat with the oldest expectation.
      function void check_beat(logic [7:0] data, logic [1:0] user, logic last);
         result_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: result beat with nothing expected: byte %0h flags %b last %b",
                     $time, data, user, last);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         beats_checked++;
         if (user[0]) bytes_seen++;
         if (user[1]) skips_seen++;
         if (last) strings_seen++;
         if (user[0] !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b actual %b", $time, want.byte_valid, user[0]);
            mismatches++;
         end
         if (data !== want.byte_out) begin
            $display("%0t: byte_out expected %02h actual %02h", $time, want.byte_out, data);
            mismatches++;
         end
         if (user[1] !== want.char_skipped) begin
            $display("%0t: char_skipped expected %b actual %b",
                     $time, want.char_skipped, user[1]);
            mismatches++;
         end
         if (last !== want.string_end) begin
            $display("%0t: string_end expected %b actual %b", $time, want.string_end, last);
            mismatches++;
         end
      endfunction
   endclass

   // Longest run of cycles without any accepted beat before the run is
   // declared hung. The single long receiver hold-off is far shorter.
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_IDLE    = 14;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we;
   logic       csr_wdata;

   decoded_byte_board board;

   // Shared between the stimulus and the receiver: whether random idling is
   // on in the current phase, and a one-shot request for a long hold-off.
   bit  idle_on;
   bit  long_hold_pending;
   int  chars_sent;
   int  quiet_cycles;

   base32_symbol_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Every accepted beat on either side goes through the scoreboard here, at
   // the rising edge, before the design's nonblocking updates land. The same
   // block runs the watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.predict_char(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL base32_symbol_decoder");
            $finish;
         end
      end
   end

   // Receiver: before every beat it stalls a random number of cycles (none
   // in phases without idling). Once it is asked for a long hold-off, it
   // keeps rsp_tready low long enough for both pipeline registers to fill
   // and for the input side to back up.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            stall             = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Offers one character and returns at the edge that accepts it. The
   // valid stays high afterwards, so a back-to-back beat never toggles it.
   task automatic send_char(logic [7:0] ch, logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      chars_sent++;
   endtask

   // Drops the input, lets every outstanding result drain, and only then
   // writes the alphabet select so that no character in flight sees it.
   task automatic write_alphabet(alphabet_type sel);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sel;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_alphabet(sel);
   endtask

   // A character that is a symbol of the given alphabet, upper or lower case.
   function automatic logic [7:0] symbol_char(alphabet_type sel);
      int         idx;
      logic [7:0] ch;
      idx = $urandom_range(0, 31);
      if (sel == ALPHA_STD) begin
         ch = (idx < 26) ? 8'("A" + idx) : 8'("2" + idx - 26);
      end else if (idx < 8) begin
         ch = 8'("A" + idx);
      end else if (idx < 13) begin
         ch = 8'("A" + idx + 1);
      end else if (idx < 24) begin
         ch = 8'("A" + idx + 2);
      end else begin
         ch = 8'("2" + idx - 24);
      end
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) begin
         ch = ch + 8'h20;
      end
      return ch;
   endfunction

   // Random traffic: mostly proper encoded strings with optional padding and
   // a sprinkle of stray bytes, the rest pure noise bursts of any byte.
   task automatic random_phase(alphabet_type sel, int count);
      int stop_at;
      int len;
      int pads;
      stop_at = chars_sent + count;
      while (chars_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            len  = $urandom_range(1, 24);
            pads = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 15) == 0) begin
                  send_char(8'($urandom_range(0, 255)), 1'b0);
               end
               send_char(symbol_char(sel), (k == len - 1) && (pads == 0));
            end
            for (int k = 0; k < pads; k++) begin
               send_char("=", k == pads - 1);
            end
         end else begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               send_char(8'($urandom_range(0, 255)), 1'(($urandom_range(0, 3) == 0)));
            end
         end
      end
   endtask

   initial begin : stimulus
      board             = new();
      idle_on           = 1'b0;
      long_hold_pending = 1'b0;
      chars_sent        = 0;
      quiet_cycles      = 0;
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tlast         = 1'b0;
      csr_we            = 1'b0;
      csr_wdata         = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Standard alphabet: a string ended on padding while seven bits are
      // still pending, letters at both ends in lower case, the digits at
      // the edges of the range, letters and digits only the legacy alphabet
      // lacks or has, and control and high Latin-1 bytes.
      write_alphabet(ALPHA_STD);
      send_char("M", 1'b0);
      send_char("Y", 1'b0);
      send_char("a", 1'b0);
      send_char("=", 1'b1);
      send_char("z", 1'b0);
      send_char("7", 1'b0);
      send_char("2", 1'b0);
      send_char("I", 1'b0);
      send_char("O", 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("1", 1'b0);
      send_char("8", 1'b1);

      // Legacy alphabet: the top digits, the letters it drops in lower case,
      // the letters on each side of the gaps, and a skipped final character.
      write_alphabet(ALPHA_LEGACY);
      idle_on = 1'b1;
      send_char("9", 1'b0);
      send_char("8", 1'b0);
      send_char("i", 1'b0);
      send_char("o", 1'b0);
      send_char("0", 1'b0);
      send_char("1", 1'b0);
      send_char("j", 1'b0);
      send_char("N", 1'b0);
      send_char("p", 1'b0);
      send_char("h", 1'b0);
      send_char("=", 1'b0);
      send_char(8'h80, 1'b1);

      // Random phases alternate the alphabet. Idling is off in two of them,
      // and the second phase asks the receiver for its long hold-off.
      for (int phase = 0; phase < 6; phase++) begin
         write_alphabet(phase % 2 ? ALPHA_LEGACY : ALPHA_STD);
         idle_on = (phase != 2) && (phase != 5);
         if (phase == 1) long_hold_pending = 1'b1;
         random_phase(phase % 2 ? ALPHA_LEGACY : ALPHA_STD, 280);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Decoded %0d characters in %0d strings under both alphabets:",
               board.beats_checked, board.strings_seen);
      $display("  %0d bytes produced, %0d characters skipped, %0d mismatches.",
               board.bytes_seen, board.skips_seen, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASS base32_symbol_decoder");
      end else begin
         $display("FAIL base32_symbol_decoder");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/b32d_pkg.sv
hw/rtl/b32d_core.sv
hw/rtl/base32_symbol_decoder.sv
bench/base32_symbol_decoder_tb.sv
